>>> hw/rtl/beacon_frame_parse_and_gap_count_defines.svh
// Assertion macros for the beacon frame parser.
`ifndef BEACON_FRAME_PARSE_AND_GAP_COUNT_DEFINES_SVH
`define BEACON_FRAME_PARSE_AND_GAP_COUNT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge outside reset.
`define BFPGC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfpgc assertion failed");
// Next-cycle implication, checked on every clock edge outside reset.
`define BFPGC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfpgc assertion failed");
`else
`define BFPGC_ASSERT_NOW(label, ante, cons)
`define BFPGC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> hw/rtl/bfpgc_pkg.sv
// Package for the beacon frame parser: parse phases, constants and byte decoders.
`timescale 1ns / 1ps

package bfpgc_pkg;

  // Text limit: only bytes at positions below LINE_BYTES-1 are parsed
  localparam int LINE_BYTES = 48;
  localparam int TAG_LEN    = 3;
  localparam int POS_W      = 8;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_T     = 8'h54;

  typedef enum logic [2:0] {
    PH_TAG        = 3'd0,
    PH_ID_WS      = 3'd1,
    PH_ID_ZERO    = 3'd2,
    PH_ID_X       = 3'd3,
    PH_ID_DIGITS  = 3'd4,
    PH_SEQ_WS     = 3'd5,
    PH_SEQ_DIGITS = 3'd6,
    PH_DONE       = 3'd7
  } phase_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  // Expected tag character at a given position
  function automatic logic [7:0] tag_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = CH_R;
      2'd1:    c = CH_T;
      default: c = CH_SPACE;
    endcase
    return c;
  endfunction

  // Space, TAB, LF, VT, FF, CR
  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic digit_t dec_digit(input logic [7:0] b);
    digit_t d;
    d.ok  = (b >= CH_ZERO) && (b <= CH_NINE);
    d.val = b[3:0];
    return d;
  endfunction

  function automatic digit_t hex_digit(input logic [7:0] b);
    digit_t d;
    logic [7:0] t;
    d.ok = 1'b0;
    d.val = 4'h0;
    if ((b >= CH_ZERO) && (b <= CH_NINE)) begin
      d.ok = 1'b1;
      d.val = b[3:0];
    end else if ((b >= CH_LC_A) && (b <= CH_LC_F)) begin
      t = b - CH_LC_A + 8'd10;
      d.ok = 1'b1;
      d.val = t[3:0];
    end else if ((b >= CH_UC_A) && (b <= CH_UC_F)) begin
      t = b - CH_UC_A + 8'd10;
      d.ok = 1'b1;
      d.val = t[3:0];
    end
    return d;
  endfunction

  // acc*16 + d, saturating at 2^32-1
  function automatic logic [31:0] hex_acc(input logic [31:0] acc, input logic [3:0] d);
    logic [31:0] r;
    if (acc[31:28] != 4'h0) r = '1;
    else r = {acc[27:0], d};
    return r;
  endfunction

  // acc*10 + d, saturating at 2^32-1
  function automatic logic [31:0] dec_acc(input logic [31:0] acc, input logic [3:0] d);
    logic [35:0] s;
    logic [31:0] r;
    s = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, d};
    if (s[35:32] != 4'h0) r = '1;
    else r = s[31:0];
    return r;
  endfunction

endpackage

>>> hw/rtl/beacon_frame_parse_and_gap_count.sv
// Beacon frame parser with per-sender sequence gap counting.
`timescale 1ns / 1ps
`include "beacon_frame_parse_and_gap_count_defines.svh"

// Usage:
// Input channel (in_valid / in_stall) carries one payload byte per word with
// frame_end on the last byte and the frame's link metrics. The frame's text
// must start with "RT ", then a hex sender id (optional 0x), then an optional
// decimal sequence number. Output channel (out_valid / out_stall) carries one
// word per accepted frame: id, sequence, gap count, frame count and the
// metrics given with the final byte.
// Throughput: one input word per cycle while in_stall is low. Parser state and
// the frame record register update at the edge that accepts the final byte;
// the gap tracking stage then writes the output register and raises out_valid
// at an edge where the pipeline advances.
// A full output register that is stalled freezes both stages and raises
// in_stall in the same cycle; nothing is dropped.
// cfg_write/cfg_data set listen_enable; while it is low, words are still
// taken but ignored and a frame in progress stays as it is.
// Reset (synchronous, rst high) clears the parser, the tracking state,
// listen_enable and both valid flags.
module beacon_frame_parse_and_gap_count (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_write,
  input  logic               cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               frame_end,
  input  logic signed [8:0]  rssi_dbm,
  input  logic signed [7:0]  snr_db,
  input  logic signed [8:0]  noise_dbm,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        sender_id,
  output logic [31:0]        sequence_res,
  output logic [31:0]        missed_total,
  output logic [31:0]        received_total,
  output logic signed [8:0]  rssi_out,
  output logic signed [7:0]  snr_out,
  output logic signed [8:0]  noise_out
);
  import bfpgc_pkg::*;

  logic                  listen_enable;

  // parser state
  logic [POS_W-1:0]      byte_position;
  phase_t                phase;
  phase_t                phase_next;
  logic [31:0]           id_acc;
  logic [31:0]           id_acc_next;
  logic [31:0]           seq_acc;
  logic [31:0]           seq_acc_next;
  logic                  hex_seen;
  logic                  hex_seen_next;

  // frame record between parser and tracking
  logic                  frm_valid;
  logic [31:0]           frm_id;
  logic [31:0]           frm_seq;
  logic signed [8:0]     frm_rssi;
  logic signed [7:0]     frm_snr;
  logic signed [8:0]     frm_noise;

  // tracking state
  logic [31:0]           previous_id;
  logic [31:0]           previous_seq;
  logic                  previous_valid;
  logic [31:0]           missed_count;
  logic [31:0]           missed_count_next;
  logic [31:0]           beacon_count;

  logic                  adv;
  logic                  in_take;
  logic                  feed_en;
  logic                  sp;
  digit_t                hd;
  digit_t                dd;
  logic                  same_sender;

  // pipeline advances unless a finished word is held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign in_take  = in_valid && adv && listen_enable;

  assign sp = is_space(rx_byte);
  assign hd = hex_digit(rx_byte);
  assign dd = dec_digit(rx_byte);
  assign feed_en = ({1'b0, byte_position} < 9'(LINE_BYTES - 1)) && (phase != PH_DONE);

  // parser next phase
  always_comb begin
    phase_next = phase;
    if (feed_en) begin
      if (rx_byte == CH_NUL) begin
        phase_next = PH_DONE;
      end else begin
        unique case (phase) inside
          PH_TAG: begin
            if ((byte_position >= POS_W'(TAG_LEN)) ||
                (rx_byte != tag_char(byte_position[1:0]))) begin
              phase_next = PH_DONE;
            end else if (byte_position == POS_W'(TAG_LEN - 1)) begin
              phase_next = PH_ID_WS;
            end
          end
          PH_ID_WS: begin
            if (!sp) begin
              if (!hd.ok) phase_next = PH_DONE;
              else if (rx_byte == CH_ZERO) phase_next = PH_ID_ZERO;
              else phase_next = PH_ID_DIGITS;
            end
          end
          PH_ID_ZERO: begin
            if ((rx_byte == CH_LC_X) || (rx_byte == CH_UC_X)) phase_next = PH_ID_X;
            else if (hd.ok) phase_next = PH_ID_DIGITS;
            else if (sp) phase_next = PH_SEQ_WS;
            else if (dd.ok) phase_next = PH_SEQ_DIGITS;
            else phase_next = PH_DONE;
          end
          PH_ID_X: begin
            phase_next = hd.ok ? PH_ID_DIGITS : PH_DONE;
          end
          PH_ID_DIGITS, PH_SEQ_WS: begin
            if (phase == PH_ID_DIGITS && hd.ok) phase_next = PH_ID_DIGITS;
            else if (sp) phase_next = PH_SEQ_WS;
            else if (dd.ok) phase_next = PH_SEQ_DIGITS;
            else phase_next = PH_DONE;
          end
          PH_SEQ_DIGITS: begin
            if (!dd.ok) phase_next = PH_DONE;
          end
          PH_DONE: begin
            phase_next = PH_DONE;
          end
          default: phase_next = PH_DONE;
        endcase
      end
    end
  end

  // parser accumulators
  always_comb begin
    id_acc_next   = id_acc;
    seq_acc_next  = seq_acc;
    hex_seen_next = hex_seen;
    if (feed_en && (rx_byte != CH_NUL)) begin
      unique case (phase) inside
        PH_ID_WS: begin
          if (!sp && hd.ok) begin
            hex_seen_next = 1'b1;
            id_acc_next   = {28'd0, hd.val};
          end
        end
        PH_ID_ZERO, PH_ID_DIGITS: begin
          if ((phase == PH_ID_ZERO) && ((rx_byte == CH_LC_X) || (rx_byte == CH_UC_X))) begin
            id_acc_next = id_acc;
          end else if (hd.ok) begin
            id_acc_next = hex_acc(id_acc, hd.val);
          end else if (!sp && dd.ok) begin
            seq_acc_next = {28'd0, dd.val};
          end
        end
        PH_ID_X: begin
          if (hd.ok) id_acc_next = {28'd0, hd.val};
        end
        PH_SEQ_WS: begin
          if (!sp && dd.ok) seq_acc_next = {28'd0, dd.val};
        end
        PH_SEQ_DIGITS: begin
          if (dd.ok) seq_acc_next = dec_acc(seq_acc, dd.val);
        end
        default: begin
          id_acc_next = id_acc;
        end
      endcase
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      listen_enable <= 1'b0;
    end else if (cfg_write) begin
      listen_enable <= cfg_data;
    end
  end

  // parser registers; a frame end restarts the parser
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      phase         <= PH_TAG;
      id_acc        <= '0;
      seq_acc       <= '0;
      hex_seen      <= 1'b0;
    end else if (in_take) begin
      if (frame_end) begin
        byte_position <= '0;
        phase         <= PH_TAG;
        id_acc        <= '0;
        seq_acc       <= '0;
        hex_seen      <= 1'b0;
      end else begin
        if (byte_position != POS_MAX) byte_position <= byte_position + 1'b1;
        phase    <= phase_next;
        id_acc   <= id_acc_next;
        seq_acc  <= seq_acc_next;
        hex_seen <= hex_seen_next;
      end
    end
  end

  // frame record
  always_ff @(posedge clk) begin
    if (rst) begin
      frm_valid <= 1'b0;
    end else if (adv) begin
      frm_valid <= in_take && frame_end && hex_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_take && frame_end) begin
      frm_id    <= id_acc_next;
      frm_seq   <= seq_acc_next;
      frm_rssi  <= rssi_dbm;
      frm_snr   <= snr_db;
      frm_noise <= noise_dbm;
    end
  end

  // gap tracking
  assign same_sender = previous_valid && (frm_id == previous_id);

  always_comb begin
    missed_count_next = missed_count;
    if (same_sender) begin
      if (frm_seq > previous_seq) begin
        missed_count_next = missed_count + frm_seq + ~previous_seq;
      end
    end else if (previous_valid) begin
      missed_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_id    <= '0;
      previous_seq   <= '0;
      previous_valid <= 1'b0;
      missed_count   <= '0;
      beacon_count   <= '0;
    end else if (adv && frm_valid) begin
      previous_id    <= frm_id;
      previous_seq   <= frm_seq;
      previous_valid <= 1'b1;
      missed_count   <= missed_count_next;
      beacon_count   <= beacon_count + 32'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= frm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && frm_valid) begin
      sender_id      <= frm_id;
      sequence_res   <= frm_seq;
      missed_total   <= missed_count_next;
      received_total <= beacon_count + 32'd1;
      rssi_out       <= frm_rssi;
      snr_out        <= frm_snr;
      noise_out      <= frm_noise;
    end
  end

  // checks
  `BFPGC_ASSERT_NOW(a_out_matches_tracking, out_valid,
    (missed_total == missed_count) && (received_total == beacon_count))
  `BFPGC_ASSERT_NOW(a_out_has_history, out_valid, previous_valid)
  `BFPGC_ASSERT_NOW(a_tag_phase_clean, phase == PH_TAG, !hex_seen)
  `BFPGC_ASSERT_NEXT(a_count_step, adv && frm_valid,
    beacon_count == $past(beacon_count) + 32'd1)

endmodule
